// ===== rtl/wcn_pkg.sv =====
// Package with the constants, types and hash helpers of the cellular noise block.
package wcn_pkg;

  localparam int FracBits  = 16;
  localparam int DistW     = 17;
  localparam int CoordW    = 32;
  localparam int NumCells  = 27;
  localparam int OffW      = FracBits + 3;        // signed offset, range about -2..+2 cells
  localparam int SqW       = 2 * FracBits + 4;    // sum of three squares
  localparam int RootSteps = DistW;               // one result bit per step

  localparam logic [31:0] HashKSeed = 32'd374761393;
  localparam logic [31:0] HashKX    = 32'd3266489917;
  localparam logic [31:0] HashKY    = 32'd2246822519;
  localparam logic [31:0] HashKZ    = 32'd668265263;
  localparam logic [31:0] HashKMix  = 32'd1274126177;

  localparam logic [1:0] RegSeed = 2'd0;

  typedef logic signed [OffW-1:0] off_t;
  typedef logic [SqW-1:0] sq_t;

  // Feature point offset from one hash byte: byte*257 scaled to FracBits.
  function automatic off_t point_off(input logic [7:0] b);
    logic [15:0] v;
    begin
      v = {8'd0, b} * 16'd257;
      point_off = off_t'(v >> (16 - FracBits));
    end
  endfunction

  // Offset of a cell index -1, 0 or +1 in fixed point.
  function automatic off_t cell_delta(input int d);
    begin
      cell_delta = off_t'(d * (1 << FracBits));
    end
  endfunction

  // Square of a signed offset at full product width.
  function automatic sq_t square_off(input off_t v);
    logic signed [2*OffW-1:0] p;
    begin
      p = v * v;
      square_off = sq_t'(p);
    end
  endfunction

endpackage

// ===== rtl/wcn_cell_eval.sv =====
// Pipelined evaluation of the 27 cells: hash, offsets, squared distance and minimum.
module wcn_cell_eval
  import wcn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [31:0]       seed_i,
  input  logic [CoordW-1:0] x_pos_i,
  input  logic [CoordW-1:0] y_pos_i,
  input  logic [CoordW-1:0] z_pos_i,
  output logic              valid_o,
  output sq_t               best_o
);

  // Stage 1: cell corner and per-axis products of the linear hash.
  logic [31:0]         hs_q;
  logic [31:0]         px_q [3];
  logic [31:0]         py_q [3];
  logic [31:0]         pz_q [3];
  logic [FracBits-1:0] fx_q, fy_q, fz_q;

  logic [31:0] xc, yc, zc;
  assign xc = 32'($signed(x_pos_i) >>> FracBits);
  assign yc = 32'($signed(y_pos_i) >>> FracBits);
  assign zc = 32'($signed(z_pos_i) >>> FracBits);

  always_ff @(posedge clk_i) begin
    hs_q <= seed_i * HashKSeed;
    for (int d = 0; d < 3; d++) begin
      px_q[d] <= (xc + 32'(d) - 32'd1) * HashKX;
      py_q[d] <= (yc + 32'(d) - 32'd1) * HashKY;
      pz_q[d] <= (zc + 32'(d) - 32'd1) * HashKZ;
    end
    fx_q <= x_pos_i[FracBits-1:0];
    fy_q <= y_pos_i[FracBits-1:0];
    fz_q <= z_pos_i[FracBits-1:0];
  end

  // Stage 2: pre-mix sum and xor-shift for every cell.
  logic [31:0]         m_q [NumCells];
  logic [FracBits-1:0] fx2_q, fy2_q, fz2_q;
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumCells; i++) begin
      m_q[i] <= (hs_q + px_q[i/9] + py_q[(i/3)%3] + pz_q[i%3])
              ^ ((hs_q + px_q[i/9] + py_q[(i/3)%3] + pz_q[i%3]) >> 13);
    end
    fx2_q <= fx_q; fy2_q <= fy_q; fz2_q <= fz_q;
  end

  // Stage 3: mixing multiply.
  logic [31:0]         g_q [NumCells];
  logic [FracBits-1:0] fx3_q, fy3_q, fz3_q;
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumCells; i++) g_q[i] <= m_q[i] * HashKMix;
    fx3_q <= fx2_q; fy3_q <= fy2_q; fz3_q <= fz2_q;
  end

  // Stage 4: final xor-shift and offsets along each axis.
  off_t ex_q [NumCells];
  off_t ey_q [NumCells];
  off_t ez_q [NumCells];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumCells; i++) begin
      ex_q[i] <= cell_delta(i/9 - 1) + point_off(g_q[i][7:0] ^ g_q[i][23:16])
               - off_t'({1'b0, fx3_q});
      ey_q[i] <= cell_delta((i/3)%3 - 1) + point_off(g_q[i][15:8] ^ g_q[i][31:24])
               - off_t'({1'b0, fy3_q});
      ez_q[i] <= cell_delta(i%3 - 1) + point_off(g_q[i][23:16])
               - off_t'({1'b0, fz3_q});
    end
  end

  // Stage 5: squares. Stage 6: sums.
  sq_t sx_q [NumCells];
  sq_t sy_q [NumCells];
  sq_t sz_q [NumCells];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumCells; i++) begin
      sx_q[i] <= square_off(ex_q[i]);
      sy_q[i] <= square_off(ey_q[i]);
      sz_q[i] <= square_off(ez_q[i]);
    end
  end

  sq_t d_q [NumCells];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumCells; i++) d_q[i] <= sx_q[i] + sy_q[i] + sz_q[i];
  end

  // Stages 7 to 9: registered minimum tree, three-to-one per level.
  sq_t t1_q [9];
  sq_t t2_q [3];
  sq_t t3_q;

  function automatic sq_t min3(input sq_t a, input sq_t b, input sq_t c);
    sq_t m;
    begin
      m = (a < b) ? a : b;
      min3 = (c < m) ? c : m;
    end
  endfunction

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) t1_q[i] <= min3(d_q[3*i], d_q[3*i+1], d_q[3*i+2]);
    for (int i = 0; i < 3; i++) t2_q[i] <= min3(t1_q[3*i], t1_q[3*i+1], t1_q[3*i+2]);
    t3_q <= min3(t2_q[0], t2_q[1], t2_q[2]);
  end

  // Valid bits travel alongside: stages 1..9.
  logic [8:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[7:0], valid_i};
    end
  end

  assign valid_o = vld_q[8];
  assign best_o  = t3_q;

endmodule

// ===== rtl/worley_cell_noise_3d.sv =====
// Top level of the 3D cellular noise block: register port, cell pipeline and square root.
//
// Usage: drive x_pos_i, y_pos_i and z_pos_i (signed Q16.16) and raise start.
// The point is taken at every rising edge where start is high; busy is
// always low because a new point can enter in every cycle.
// Each point yields one beat on distance_o (unsigned Q1.16, floor of the
// distance to the nearest feature point among the 27 surrounding cells),
// marked by done_o for exactly one cycle.
// The cell pipeline runs through hash, mix multiply, offsets, squares, sums and
// three levels of a minimum tree, and is followed by the square root, which
// gives one result bit per stage.
// Throughput is one point per cycle, set by the fully unrolled 27-cell array.
// The receiver cannot stall: results appear in order, one per accepted point.
// The seed register sits at byte address 0 of the APB port; the user must write
// it only while no point is in flight, as the block itself does not enforce this.
// Reset clears the seed to zero and drops every beat in flight.
module worley_cell_noise_3d
  import wcn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic [CoordW-1:0] x_pos_i,
  input  logic [CoordW-1:0] y_pos_i,
  input  logic [CoordW-1:0] z_pos_i,
  output logic              done_o,
  output logic [DistW-1:0]  distance_o
);

  // Configuration register. Only the seed exists; other addresses are ignored.
  logic [31:0] seed_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (psel && penable && pwrite && paddr == RegSeed) begin
      seed_q <= pwdata;
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == RegSeed) ? seed_q : 32'd0;
  assign busy   = 1'b0;

  logic cv;
  sq_t  best;
  wcn_cell_eval u_eval (
    .clk_i, .rst_ni,
    .valid_i (start),
    .seed_i  (seed_q),
    .x_pos_i, .y_pos_i, .z_pos_i,
    .valid_o (cv),
    .best_o  (best)
  );

  // Restoring square root, one result bit per stage. Stage k decides bit
  // RootSteps-1-k; rad_q carries the unconsumed radicand, rem_q the partial remainder.
  localparam int RemW = SqW + 2;
  logic [RootSteps-1:0] sv_q;
  logic [SqW-1:0]       rad_q  [1:RootSteps];
  logic [RemW-1:0]      rem_q  [1:RootSteps];
  logic [DistW-1:0]     root_q [1:RootSteps];

  for (genvar k = 0; k < RootSteps; k++) begin : g_root
    logic [SqW-1:0]   rad_in;
    logic [RemW-1:0]  rem_in, r_sh, trial;
    logic [DistW-1:0] root_in;
    if (k == 0) begin : g_first
      // The nearest point is never farther than the feature point of the
      // point's own cell, so the squared distance stays below 3 * 2^32 and
      // its two top bits are always zero; the 17 steps take the 34 bits below.
      assign rad_in  = {best[SqW-3:0], 2'b00};
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k];
      assign rem_in  = rem_q[k];
      assign root_in = root_q[k];
    end
    assign r_sh  = {rem_in[RemW-3:0], rad_in[SqW-1 -: 2]};
    assign trial = RemW'({root_in, 2'b01});
    always_ff @(posedge clk_i) begin
      rad_q[k+1] <= {rad_in[SqW-3:0], 2'b00};
      if (r_sh >= trial) begin
        rem_q[k+1]  <= r_sh - trial;
        root_q[k+1] <= {root_in[DistW-2:0], 1'b1};
      end else begin
        rem_q[k+1]  <= r_sh;
        root_q[k+1] <= {root_in[DistW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else begin
      sv_q <= {sv_q[RootSteps-2:0], cv};
    end
  end

  assign done_o     = sv_q[RootSteps-1];
  assign distance_o = root_q[RootSteps];

  // The pipeline never refuses a point.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  // Each accepted point is followed by a result on done_o.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##26 done_o) else $error("result missing");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> sv_q[RootSteps-1]) else $error("spurious result");

endmodule
